// ----- src/partition_table_entry_checker_top_defines.svh -----
// Assertion helpers used by the port checker
`ifndef PARTITION_TABLE_ENTRY_CHECKER_TOP_DEFINES_SVH
`define PARTITION_TABLE_ENTRY_CHECKER_TOP_DEFINES_SVH

// same-cycle implication
`define PTEC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ptec_pkg.sv -----
`timescale 1ns / 1ps
package ptec_pkg;

   localparam logic [2:0] ST_UNUSED   = 3'd0;
   localparam logic [2:0] ST_VALID    = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_REVERSED = 3'd3;
   localparam logic [2:0] ST_ZERO_UID = 3'd4;
   localparam logic [2:0] ST_OVERLAP  = 3'd5;
   localparam logic [2:0] ST_SKIPPED  = 3'd6;
   localparam logic [2:0] ST_TOO_MANY = 3'd7;

   localparam logic CSR_USABLE_FIRST = 1'b0;
   localparam logic CSR_USABLE_LAST  = 1'b1;

   localparam int BLK_W = 64;

   typedef struct packed {
      logic [63:0] type_id_low;
      logic [63:0] type_id_high;
      logic [63:0] unique_id_low;
      logic [63:0] unique_id_high;
      logic [63:0] start_block;
      logic [63:0] end_block;
      logic        final_entry;
   } req_beat_type;

   typedef struct packed {
      logic [2:0] entry_status;
      logic       table_ok;
      logic [7:0] valid_count;
      logic [7:0] entry_count;
      logic       table_done;
   } rsp_beat_type;

   typedef struct packed {
      logic [BLK_W-1:0] a0;
      logic [BLK_W-1:0] b0;
      logic [BLK_W-1:0] a1;
      logic [BLK_W-1:0] b1;
   } cmp_req_type;

   typedef struct packed {
      logic le0;
      logic le1;
   } cmp_rsp_type;

endpackage

// ----- src/ptec_ram.sv -----
`timescale 1ns / 1ps
module ptec_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 128
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/ptec_cmp.sv -----
`timescale 1ns / 1ps
module ptec_cmp (
   input  ptec_pkg::cmp_req_type cmp_req,
   output ptec_pkg::cmp_rsp_type cmp_rsp
);
   import ptec_pkg::*;

   // two unsigned a <= b compares, shared by every check step
   assign cmp_rsp.le0 = (cmp_req.a0 <= cmp_req.b0);
   assign cmp_rsp.le1 = (cmp_req.a1 <= cmp_req.b1);
endmodule

// ----- src/ptec_seq.sv -----
`timescale 1ns / 1ps
module ptec_seq #(
   parameter int MAX_ENTRIES = 128
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                req_valid,
   output logic                                                req_stall,
   input  ptec_pkg::req_beat_type                              req_data,
   output logic                                                rsp_valid,
   input  logic                                                rsp_stall,
   output ptec_pkg::rsp_beat_type                              rsp_data,
   input  logic [63:0]                                         usable_first,
   input  logic [63:0]                                         usable_last,
   output ptec_pkg::cmp_req_type                               cmp_req,
   input  ptec_pkg::cmp_rsp_type                               cmp_rsp,
   output logic                                                ram_wr_en,
   output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] ram_wr_addr,
   output logic [2*ptec_pkg::BLK_W-1:0]                        ram_wr_data,
   output logic                                                ram_rd_en,
   output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] ram_rd_addr,
   input  logic [2*ptec_pkg::BLK_W-1:0]                        ram_rd_data
);
   import ptec_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int SW = (CW > 8) ? CW : 9;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHK_RANGE,
      S_CHK_ORDER,
      S_SCAN,
      S_COMMIT
   } state_type;

   state_type      state_ff, state_in;
   logic [63:0]    start_ff, start_in;
   logic [63:0]    end_ff, end_in;
   logic           final_ff, final_in;
   logic           unused_ff, unused_in;
   logic           zuid_ff, zuid_in;
   logic [2:0]     status_ff, status_in;
   logic [CW-1:0]  stored_ff, stored_in;
   logic [CW-1:0]  seen_ff, seen_in;
   logic           failed_ff, failed_in;
   logic [CW-1:0]  scan_ff, scan_in;
   logic           pend_ff, pend_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_beat_type   rsp_data_ff, rsp_data_in;

   logic           slot_free;
   logic           issue;
   logic           store_it;
   logic           fail_it;
   logic [CW-1:0]  stored_nx;
   logic [CW-1:0]  seen_nx;
   logic [63:0]    rd_start;
   logic [63:0]    rd_end;

   function automatic logic [7:0] sat8(input logic [CW-1:0] c);
      logic [SW-1:0] v;
      v = SW'(c);
      sat8 = (v > SW'(255)) ? 8'hFF : v[7:0];
   endfunction

   assign rd_start  = ram_rd_data[2*BLK_W-1:BLK_W];
   assign rd_end    = ram_rd_data[BLK_W-1:0];
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign issue     = (scan_ff < stored_ff);
   assign store_it  = (status_ff == ST_VALID) && (stored_ff < CW'(MAX_ENTRIES));
   assign fail_it   = (status_ff != ST_UNUSED) && (status_ff != ST_VALID) &&
                      (status_ff != ST_SKIPPED);
   assign stored_nx = store_it ? stored_ff + CW'(1) : stored_ff;
   assign seen_nx   = (seen_ff < CW'(MAX_ENTRIES)) ? seen_ff + CW'(1) : seen_ff;

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      final_in     = final_ff;
      unused_in    = unused_ff;
      zuid_in      = zuid_ff;
      status_in    = status_ff;
      stored_in    = stored_ff;
      seen_in      = seen_ff;
      failed_in    = failed_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmp_req      = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = stored_ff[AW-1:0];
      ram_wr_data  = {start_ff, end_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               start_in  = req_data.start_block;
               end_in    = req_data.end_block;
               final_in  = req_data.final_entry;
               unused_in = (req_data.type_id_low == '0) && (req_data.type_id_high == '0);
               zuid_in   = (req_data.unique_id_low == '0) && (req_data.unique_id_high == '0);
               state_in  = S_CHK_RANGE;
            end
         end
         S_CHK_RANGE: begin
            cmp_req.a0 = usable_first;
            cmp_req.b0 = start_ff;
            cmp_req.a1 = end_ff;
            cmp_req.b1 = usable_last;
            state_in   = S_COMMIT;
            if (failed_ff) begin
               status_in = ST_SKIPPED;
            end else if (seen_ff >= CW'(MAX_ENTRIES)) begin
               status_in = ST_TOO_MANY;
            end else if (unused_ff) begin
               status_in = ST_UNUSED;
            end else if (!(cmp_rsp.le0 && cmp_rsp.le1)) begin
               status_in = ST_RANGE;
            end else begin
               state_in = S_CHK_ORDER;
            end
         end
         S_CHK_ORDER: begin
            cmp_req.a0 = start_ff;
            cmp_req.b0 = end_ff;
            state_in   = S_COMMIT;
            if (!cmp_rsp.le0) begin
               status_in = ST_REVERSED;
            end else if (zuid_ff) begin
               status_in = ST_ZERO_UID;
            end else begin
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // read one stored range per cycle, compare it the cycle after
            cmp_req.a0 = start_ff;
            cmp_req.b0 = rd_end;
            cmp_req.a1 = rd_start;
            cmp_req.b1 = end_ff;
            if (pend_ff && cmp_rsp.le0 && cmp_rsp.le1) begin
               status_in = ST_OVERLAP;
               pend_in   = 1'b0;
               state_in  = S_COMMIT;
            end else if (!issue) begin
               status_in = ST_VALID;
               pend_in   = 1'b0;
               state_in  = S_COMMIT;
            end else begin
               ram_rd_en = 1'b1;
               scan_in   = scan_ff + CW'(1);
               pend_in   = 1'b1;
            end
         end
         S_COMMIT: begin
            if (slot_free) begin
               ram_wr_en                = store_it;
               rsp_valid_in             = 1'b1;
               rsp_data_in.entry_status = status_ff;
               rsp_data_in.table_ok     = !(failed_ff || fail_it);
               rsp_data_in.valid_count  = sat8(stored_nx);
               rsp_data_in.entry_count  = sat8(seen_nx);
               rsp_data_in.table_done   = final_ff;
               if (final_ff) begin
                  stored_in = '0;
                  seen_in   = '0;
                  failed_in = 1'b0;
               end else begin
                  stored_in = stored_nx;
                  seen_in   = seen_nx;
                  failed_in = failed_ff || fail_it;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      end_ff      <= end_in;
      final_ff    <= final_in;
      unused_ff   <= unused_in;
      zuid_ff     <= zuid_in;
      status_ff   <= status_in;
      scan_ff     <= scan_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         stored_ff    <= '0;
         seen_ff      <= '0;
         failed_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         seen_ff      <= seen_in;
         failed_ff    <= failed_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ----- src/partition_table_entry_checker_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Beat             Handshake
// req_      in         req_beat_type    req_valid / req_stall
// rsp_      out        rsp_beat_type    rsp_valid / rsp_stall
// csr_      in         index + 64 bits  csr_wr_en, no wait
//
// One entry at a time: a used entry that passes range and order is checked, then scans
// the ranges stored so far in this table (one range RAM read per cycle), then commits;
// an overlap ends the scan early. Reversed and zero id entries commit after order check,
// skipped, too many, unused and out-of-range entries right after the range check.
// Synchronous active-high reset clears counts and handshake state; the RAM is not cleared.
// A stalled result holds in the output register; the next entry waits only in commit.
module partition_table_entry_checker_top #(
   parameter int MAX_ENTRIES = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ptec_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ptec_pkg::rsp_beat_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [63:0]            csr_wr_data
);
   import ptec_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic [63:0]         usable_first_ff, usable_first_in;
   logic [63:0]         usable_last_ff, usable_last_in;
   cmp_req_type         cmp_req;
   cmp_rsp_type         cmp_rsp;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [2*BLK_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [2*BLK_W-1:0]  ram_rd_data;

   always_comb begin
      usable_first_in = usable_first_ff;
      usable_last_in  = usable_last_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_USABLE_FIRST: usable_first_in = csr_wr_data;
            CSR_USABLE_LAST:  usable_last_in  = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_first_ff <= '0;
         usable_last_ff  <= '1;
      end else begin
         usable_first_ff <= usable_first_in;
         usable_last_ff  <= usable_last_in;
      end
   end

   ptec_seq #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .usable_first (usable_first_ff),
      .usable_last  (usable_last_ff),
      .cmp_req      (cmp_req),
      .cmp_rsp      (cmp_rsp),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

   ptec_cmp u_cmp (
      .cmp_req (cmp_req),
      .cmp_rsp (cmp_rsp)
   );

   ptec_ram #(
      .WIDTH (2 * BLK_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ranges (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );
endmodule

// ----- src/ptec_port_checker.sv -----
`timescale 1ns / 1ps
`include "partition_table_entry_checker_top_defines.svh"
module ptec_port_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input ptec_pkg::req_beat_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input ptec_pkg::rsp_beat_type rsp_data
);
   import ptec_pkg::*;

   logic rsp_fail_code;
   logic req_beat;

   assign req_beat      = req_valid && !req_stall && (req_data.final_entry || 1'b1);
   assign rsp_fail_code = (rsp_data.entry_status == ST_RANGE) ||
                          (rsp_data.entry_status == ST_REVERSED) ||
                          (rsp_data.entry_status == ST_ZERO_UID) ||
                          (rsp_data.entry_status == ST_OVERLAP) ||
                          (rsp_data.entry_status == ST_TOO_MANY);

   `PTEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled rsp beat changed")
   `PTEC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, req_stall, "req taken while previous entry in progress")
   `PTEC_ASSERT_NOW(a_fail_clears_ok, clock, reset, rsp_valid && rsp_fail_code, !rsp_data.table_ok, "failing entry reported table ok")
   `PTEC_ASSERT_NOW(a_valid_counted, clock, reset, rsp_valid && rsp_data.entry_status == ST_VALID, rsp_data.table_ok && rsp_data.valid_count != 8'd0, "valid entry not counted")
   `PTEC_ASSERT_NOW(a_count_order, clock, reset, rsp_valid, rsp_data.valid_count <= rsp_data.entry_count, "valid count above entry count")
endmodule

bind partition_table_entry_checker_top ptec_port_checker u_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
